@@ src/rpa_pkg.sv @@
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types, constants and AES-128 helper functions for the address
// resolver pipeline.
// ----------------------------------------------------------------------------
package rpa_pkg;

  // Number of AES rounds, and variants tried per address.
  localparam int NumRounds   = 10;
  localparam int NumVariants = 4;
  localparam int VarBits     = $clog2(NumVariants);

  // Register indexes of the configuration port.
  localparam logic [1:0] RegKeyUpper = 2'd0;
  localparam logic [1:0] RegKeyLower = 2'd1;
  localparam logic [1:0] RegEnable   = 2'd2;

  // A prand qualifies when its top two bits are 01.
  localparam logic [7:0] PrandTypeMask = 8'hC0;
  localparam logic [7:0] PrandTypeRpa  = 8'h40;

  // One block in flight: cipher state, current round key, hash to compare.
  typedef struct packed {
    logic         valid;
    logic         last;
    logic         ok;
    logic [23:0]  hash;
    logic [127:0] rk;
    logic [127:0] st;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // Byte i of a 128-bit block sits in bits 127-8i down to 120-8i.
  function automatic logic [7:0] get_byte(input logic [127:0] v, input int i);
    return v[127-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes followed by ShiftRows.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[127-8*(c*4+i) -: 8] = SBOX[get_byte(s, ((c + i) % 4) * 4 + i)];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = get_byte(s, c*4);
      a1  = get_byte(s, c*4+1);
      a2  = get_byte(s, c*4+2);
      a3  = get_byte(s, c*4+3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127-8*(c*4)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[127-8*(c*4+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[127-8*(c*4+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[127-8*(c*4+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // One step of the AES-128 key schedule.
  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, tmp;
    w0  = k[127:96];
    w1  = k[95:64];
    w2  = k[63:32];
    w3  = k[31:0];
    tmp = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0  = w0 ^ tmp;
    w1  = w1 ^ w0;
    w2  = w2 ^ w1;
    w3  = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] byte_reverse(input logic [127:0] k);
    logic [127:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = get_byte(k, 15 - i);
    end
    return r;
  endfunction

endpackage

@@ src/rpa_issue.sv @@
// ----------------------------------------------------------------------------
// rpa_issue
// Holds one address and issues its four cipher blocks, one per cycle unless
// stalled, each with the key, hash and prand check that belong to that variant.
// ----------------------------------------------------------------------------
module rpa_issue
  import rpa_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [47:0]  addr_in,
  input  logic [127:0] key,
  input  logic         enable,
  output stage_t       dout
);

  logic               busy;
  logic [VarBits-1:0] cnt;
  logic [47:0]        addr;
  logic               last_issue;
  logic [23:0]        prand, hash;
  logic [127:0]       vkey;

  // No transfer is taken while reset is held.
  assign last_issue = busy && en && (cnt == VarBits'(NumVariants - 1));
  assign in_ready   = !rst && (!busy || last_issue);

  // Variant order: low half as prand, then high half; first key, then reversed.
  always_comb begin
    prand = cnt[0] ? addr[47:24] : addr[23:0];
    hash  = cnt[0] ? addr[23:0]  : addr[47:24];
    vkey  = cnt[1] ? byte_reverse(key) : key;
  end

  // Sequencer: load an address, then step through its variants.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else begin
      if (busy && en) begin
        cnt <= cnt + 1'b1;
        if (last_issue) begin
          busy <= 1'b0;
        end
      end
      if (in_valid && in_ready) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      addr <= addr_in;
    end
  end

  // Initial AddRoundKey into the first pipeline register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.last <= (cnt == VarBits'(NumVariants - 1));
      dout.ok   <= enable && ((prand[23:16] & PrandTypeMask) == PrandTypeRpa);
      dout.hash <= hash;
      dout.rk   <= vkey;
      dout.st   <= {104'b0, prand} ^ vkey;
    end
  end

endmodule

@@ src/rpa_round.sv @@
// ----------------------------------------------------------------------------
// rpa_round
// One registered AES-128 round, with its key schedule step alongside.
// ----------------------------------------------------------------------------
module rpa_round
  import rpa_pkg::*;
#(
  parameter int ROUND = 1
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  stage_t din,
  output stage_t dout
);

  logic [127:0] rk_new;
  logic [127:0] mixed;

  // Round key and round function; the last round has no MixColumns.
  always_comb begin
    rk_new = key_next(din.rk, RCON[ROUND-1]);
    if (ROUND == NumRounds) begin
      mixed = sub_shift(din.st);
    end else begin
      mixed = mix_columns(sub_shift(din.st));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.last <= din.last;
      dout.ok   <= din.ok;
      dout.hash <= din.hash;
      dout.rk   <= rk_new;
      dout.st   <= mixed ^ rk_new;
    end
  end

endmodule

@@ src/rpa_collect.sv @@
// ----------------------------------------------------------------------------
// rpa_collect
// Compares each cipher block with its hash, merges the four variants of an
// address and holds the result in the output register.
// ----------------------------------------------------------------------------
module rpa_collect
  import rpa_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  stage_t din,
  output logic   en,
  output logic   out_valid,
  input  logic   out_ready,
  output logic   matched
);

  logic acc;
  logic hit;

  // The pipeline moves whenever the output register is free or being taken.
  assign en = !out_valid || out_ready;

  assign hit = din.ok && ((din.st[23:0] == din.hash) || (din.st[127:104] == din.hash));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc       <= 1'b0;
    end else if (en) begin
      out_valid <= din.valid && din.last;
      if (din.valid) begin
        acc <= din.last ? 1'b0 : (acc | hit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && din.valid && din.last) begin
      matched <= acc | hit;
    end
  end

endmodule

@@ src/rpa_resolver_aes128.sv @@
// ----------------------------------------------------------------------------
// rpa_resolver_aes128
// Resolvable private address check against a 128-bit identity key, built on
// an unrolled, fully registered AES-128 pipeline.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                          Payload
//  s_axis    in         s_axis_tvalid/tready/tdata       device_address
//  m_axis    out        m_axis_tvalid/tready/tdata       matched
//  cfg       in         cfg_valid/cfg_ready/cfg_index    cfg_data (64 bits)
//
// An address is held while its four cipher blocks enter the round pipeline
// one per cycle, unless m_axis stalls; the next address is taken as the last
// block of the previous one issues. The result passes the first register,
// ten round stages and the output register. Reset clears all valid bits,
// the sequencer and the configuration registers; no transfer is taken
// while reset is held. A stall at m_axis freezes the whole pipeline in
// place; while a result waits, an address is still taken if none is held.
// ----------------------------------------------------------------------------
module rpa_resolver_aes128
  import rpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [47:0] device_address
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] matched, [7:1] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] key_upper, key_lower;
  logic        resolve_enable;
  logic        en;
  logic        matched;
  stage_t      stg [NumRounds+1];

  // Configuration registers.
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper      <= '0;
      key_lower      <= '0;
      resolve_enable <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegKeyUpper: key_upper      <= cfg_data;
        RegKeyLower: key_lower      <= cfg_data;
        RegEnable:   resolve_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rpa_issue u_issue (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .addr_in  (s_axis_tdata),
    .key      ({key_upper, key_lower}),
    .enable   (resolve_enable),
    .dout     (stg[0])
  );

  // Ten round stages.
  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    rpa_round #(.ROUND(r)) u_round (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (stg[r-1]),
      .dout (stg[r])
    );
  end

  rpa_collect u_collect (
    .clk       (clk),
    .rst       (rst),
    .din       (stg[NumRounds]),
    .en        (en),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .matched   (matched)
  );

  assign m_axis_tdata = {7'b0, matched};

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address resolver testbench
// Drives device addresses into the resolver under several key settings and
// checks each match flag against a behavioral AES-128 resolver. Stimulus is
// a short table of directed addresses followed by random addresses, about
// half of them built to resolve under the current key, so both outcomes occur.
// ----------------------------------------------------------------------------
module testbench;
  import rpa_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // [47:0] device_address
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [0] matched, [7:1] zero
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  rpa_resolver_aes128 u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int PipeLatency = 16;
  localparam int CycleLimit  = 400000;
  localparam logic [1:0] RegUnused = 2'd3;

  // Predictor state: its own copy of the registers.
  logic [63:0] key_hi_q;
  logic [63:0] key_lo_q;
  logic        enable_q;

  // Expected match flags, oldest first.
  logic        match_queue[$];
  int          errors;
  int          mismatches;
  int          cycles;
  int          sent;
  int          hits;
  int          src_idle_pct;
  int          dst_idle_pct;

  // Lookup tables for the predictor, filled once at start.
  logic [7:0]  sb[256];
  logic [7:0]  rc[10];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] gmul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // AES-128 encryption on byte arrays, byte 0 first.
  function automatic void encrypt_block(input logic [7:0] key[16],
                                        input logic [7:0] pt[16],
                                        output logic [7:0] ct[16]);
    logic [7:0] rk[176];
    logic [7:0] s[16];
    logic [7:0] t[16];
    logic [7:0] w0, w1, w2, w3, tmp, a0, a1, a2, a3, al;
    for (int i = 0; i < 16; i++) rk[i] = key[i];
    for (int i = 16; i < 176; i += 4) begin
      w0 = rk[i-4]; w1 = rk[i-3]; w2 = rk[i-2]; w3 = rk[i-1];
      if (i % 16 == 0) begin
        tmp = w0;
        w0 = sb[w1] ^ rc[i/16 - 1];
        w1 = sb[w2];
        w2 = sb[w3];
        w3 = sb[tmp];
      end
      rk[i] = rk[i-16] ^ w0; rk[i+1] = rk[i-15] ^ w1;
      rk[i+2] = rk[i-14] ^ w2; rk[i+3] = rk[i-13] ^ w3;
    end
    for (int i = 0; i < 16; i++) s[i] = pt[i] ^ rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[c*4+i] = sb[s[((c+i)%4)*4+i]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[c*4]   = a0 ^ al ^ gmul2(a0 ^ a1);
          t[c*4+1] = a1 ^ al ^ gmul2(a1 ^ a2);
          t[c*4+2] = a2 ^ al ^ gmul2(a2 ^ a3);
          t[c*4+3] = a3 ^ al ^ gmul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[r*16+i];
    end
    for (int i = 0; i < 16; i++) ct[i] = s[i];
  endfunction

  // Builds the forward or byte-reversed key from the registers.
  function automatic void key_bytes(input logic reversed, output logic [7:0] k[16]);
    logic [127:0] kv;
    kv = {key_hi_q, key_lo_q};
    for (int i = 0; i < 16; i++)
      k[reversed ? 15 - i : i] = kv[127-8*i -: 8];
  endfunction

  // Cipher of 13 zero bytes and the prand, first three and last three bytes.
  function automatic logic [47:0] prand_cipher(input logic reversed, input logic [23:0] prand);
    logic [7:0] k[16];
    logic [7:0] pt[16];
    logic [7:0] ct[16];
    key_bytes(reversed, k);
    for (int i = 0; i < 16; i++) pt[i] = 8'h00;
    pt[13] = prand[23:16]; pt[14] = prand[15:8]; pt[15] = prand[7:0];
    encrypt_block(k, pt, ct);
    return {ct[0], ct[1], ct[2], ct[13], ct[14], ct[15]};
  endfunction

  function automatic logic half_resolves(input logic [23:0] prand, input logic [23:0] hash);
    logic [47:0] c;
    if ((prand[23:16] & PrandTypeMask) != PrandTypeRpa) return 1'b0;
    for (int v = 0; v < 2; v++) begin
      c = prand_cipher(v[0], prand);
      if (c[47:24] == hash || c[23:0] == hash) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic address_matches(input logic [47:0] addr);
    if (!enable_q) return 1'b0;
    return half_resolves(addr[23:0], addr[47:24]) || half_resolves(addr[47:24], addr[23:0]);
  endfunction

  // Random address that resolves under the current key, in one of the
  // eight variants picked at random.
  function automatic logic [47:0] resolvable_address();
    logic [23:0] prand;
    logic [47:0] c;
    logic [23:0] hash;
    prand = {2'b01, 22'($urandom)};
    c = prand_cipher(1'($urandom), prand);
    hash = $urandom_range(0, 1) ? c[47:24] : c[23:0];
    return $urandom_range(0, 1) ? {hash, prand} : {prand, hash};
  endfunction

  // One register write; the channel idles afterwards.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      RegKeyUpper: key_hi_q = value;
      RegKeyLower: key_lo_q = value;
      RegEnable:   enable_q = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // One address transfer with random sender gaps; records the expectation.
  // Valid stays high into the next transfer unless the sender idles.
  task automatic send_address(input logic [47:0] addr);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    do @(posedge clk); while (!s_axis_tready);
    match_queue.push_back(address_matches(addr));
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (match_queue.size() != 0) @(posedge clk);
    repeat (PipeLatency + 4) @(posedge clk);
  endtask

  // Receiver stall pattern.
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
  end

  // Result checker.
  always @(posedge clk) begin
    logic expected;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (match_queue.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("Unexpected result %h", m_axis_tdata);
      end else begin
        expected = match_queue.pop_front();
        if (m_axis_tdata !== {7'd0, expected}) begin
          errors++;
          if (mismatches++ < 10)
            $display("Mismatch: expected %h, got %h", {7'd0, expected}, m_axis_tdata);
        end
        hits += expected;
      end
    end
  end

  typedef struct {
    logic [47:0] addr;
    logic        check_fixed;
    logic        fixed_match;
  } vector_t;

  initial begin
    vector_t vec[$];
    logic [63:0] khi[4];
    logic [63:0] klo[4];

    sb = SBOX;
    rc = RCON;
    errors = 0; mismatches = 0; cycles = 0; sent = 0; hits = 0;
    src_idle_pct = 13; dst_idle_pct = 55;
    key_hi_q = '0; key_lo_q = '0; enable_q = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    cfg_valid = 1'b0; cfg_index = RegKeyUpper; cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: after reset resolution is disabled, so the fixed
    // rows expect no match; every row's result is checked against the predictor.
    vec.push_back('{48'h0000_0000_0000, 1'b1, 1'b0});
    vec.push_back('{48'hFFFF_FFFF_FFFF, 1'b1, 1'b0});
    vec.push_back('{48'h4000_0040_0000, 1'b1, 1'b0});
    foreach (vec[i]) begin
      send_address(vec[i].addr);
      if (vec[i].check_fixed && match_queue[$] !== vec[i].fixed_match) errors++;
    end
    drain();

    // Writes to an unused index must have no effect.
    write_reg(RegUnused, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(RegKeyUpper, 64'h0011_2233_4455_6677);
    write_reg(RegKeyLower, 64'h8899_AABB_CCDD_EEFF);
    write_reg(RegEnable, 64'hFFFF_FFFF_FFFF_FFFF);
    vec.delete();
    // Neither half qualifies, prand extremes, and each half as prand.
    vec.push_back('{48'h0000_0000_0000, 1'b1, 1'b0});
    vec.push_back('{48'hFFFF_FFFF_FFFF, 1'b1, 1'b0});
    vec.push_back('{48'h8000_00C0_0000, 1'b1, 1'b0});
    vec.push_back('{48'h4000_0000_0000, 1'b0, 1'b0});
    vec.push_back('{48'h7FFF_FF7F_FFFF, 1'b0, 1'b0});
    vec.push_back('{48'h4000_0040_0000, 1'b0, 1'b0});
    vec.push_back('{48'hAAAA_AA55_5555, 1'b0, 1'b0});
    vec.push_back('{48'h5555_55AA_AAAA, 1'b0, 1'b0});
    for (int i = 0; i < 8; i++) vec.push_back('{resolvable_address(), 1'b0, 1'b0});
    foreach (vec[i]) begin
      send_address(vec[i].addr);
      if (vec[i].check_fixed && match_queue[$] !== vec[i].fixed_match) errors++;
    end
    drain();

    // Random part across several key settings, including the extremes.
    khi = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0};
    klo = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0};
    khi[2] = {$urandom, $urandom}; klo[2] = {$urandom, $urandom};
    khi[3] = {$urandom, $urandom}; klo[3] = {$urandom, $urandom};
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin src_idle_pct = 55; dst_idle_pct = 13; end
      if (phase == 4) begin src_idle_pct = 0;  dst_idle_pct = 0;  end
      write_reg(RegKeyUpper, khi[phase % 4]);
      write_reg(RegKeyLower, klo[phase % 4]);
      write_reg(RegEnable, (phase == 3) ? 64'h0 : {$urandom, $urandom} | 64'h1);
      for (int n = 0; n < 270; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: send_address(resolvable_address());
          5, 6: send_address(48'({$urandom, $urandom}) & 48'h3FFF_FF3F_FFFF |
                             48'h4000_0040_0000);
          default: send_address(48'({$urandom, $urandom}));
        endcase
      end
      drain();
    end

    $display("Sent %0d addresses over six key settings; %0d results matched.", sent, hits);
    if (errors == 0 && match_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d failures", errors + match_queue.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ rpa_resolver_aes128.f @@
src/rpa_pkg.sv
src/rpa_issue.sv
src/rpa_round.sv
src/rpa_collect.sv
src/rpa_resolver_aes128.sv
verif/testbench.sv
